// ===== hdl/ntpm_pkg.sv =====
// shared types, constants and codes of the nearest template point matcher
package ntpm_pkg;

   // default sizes of the template table and coordinate precision
   localparam int CLASS_COUNT_DEF = 64;
   localparam int SIZE_COUNT_DEF  = 8;
   localparam int COORD_BITS_DEF  = 16;

   // fixed field widths
   localparam int KIND_W  = 2;
   localparam int CLASS_W = 6;
   localparam int SIZE_W  = 3;
   localparam int COORD_W = 16;
   localparam int REG_W   = 17;
   localparam int CSR_W   = 2;

   // squared distances, errors and squared thresholds
   localparam int DIST_W = 2 * REG_W;

   // register reset values
   localparam logic [REG_W-1:0] START_DISTANCE_RST   = 17'd131071;
   localparam logic [REG_W-1:0] PAIR_THRESHOLD_RST   = 17'd4096;
   localparam logic [REG_W-1:0] SINGLE_THRESHOLD_RST = 17'd2048;

   typedef enum logic [CSR_W-1:0] {
      CSR_START_DISTANCE   = 2'd0,
      CSR_PAIR_THRESHOLD   = 2'd1,
      CSR_SINGLE_THRESHOLD = 2'd2
   } csr_index_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD   = 2'd0,
      KIND_PAIR   = 2'd1,
      KIND_SINGLE = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic [CLASS_W-1:0]   class_index;
      logic [SIZE_W-1:0]    size_index;
      logic [COORD_W-1:0]   first_x;
      logic [COORD_W-1:0]   first_y;
      logic [COORD_W-1:0]   second_x;
      logic [COORD_W-1:0]   second_y;
   } req_type;

   typedef struct packed {
      logic [CLASS_W-1:0]   match_class;
      logic                 found;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic load_wr;
      logic start_query;
      logic clr_step;
      logic scan_step;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_is_load;
      logic req_is_scan;
      logic clr_last;
      logic scan_last;
      logic pipe_busy;
      logic out_free;
   } status_type;

endpackage

// ===== hdl/ntpm_ram.sv =====
// generic simple dual port ram with registered read
module ntpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/ntpm_ctrl.sv =====
// sequencer for table clearing, loads and query scans
module ntpm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ntpm_pkg::status_type  status,
   output ntpm_pkg::cmd_type     cmd
);

   ntpm_pkg::ctrl_state_type state_ff;
   ntpm_pkg::ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ntpm_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ntpm_pkg::ST_CLEAR: begin
            if (status.clr_last) state_in = ntpm_pkg::ST_IDLE;
         end
         ntpm_pkg::ST_IDLE: begin
            if (req_valid && !status.req_is_load) begin
               state_in = status.req_is_scan ? ntpm_pkg::ST_SCAN : ntpm_pkg::ST_DONE;
            end
         end
         ntpm_pkg::ST_SCAN: begin
            if (status.scan_last) state_in = ntpm_pkg::ST_DRAIN;
         end
         ntpm_pkg::ST_DRAIN: begin
            if (!status.pipe_busy) state_in = ntpm_pkg::ST_DONE;
         end
         ntpm_pkg::ST_DONE: begin
            if (status.out_free) state_in = ntpm_pkg::ST_IDLE;
         end
         default: begin
            state_in = ntpm_pkg::ST_CLEAR;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ntpm_pkg::ST_CLEAR: begin
            cmd.clr_step = 1'b1;
         end
         ntpm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_wr     = status.req_is_load;
               cmd.start_query = !status.req_is_load;
            end
         end
         ntpm_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         ntpm_pkg::ST_DRAIN: begin
            cmd = '0;
         end
         ntpm_pkg::ST_DONE: begin
            cmd.finish = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== hdl/ntpm_datapath.sv =====
// template table, distance pipeline, best match tracking and result register
module ntpm_datapath #(
   parameter int CLASS_COUNT = ntpm_pkg::CLASS_COUNT_DEF,
   parameter int SIZE_COUNT  = ntpm_pkg::SIZE_COUNT_DEF,
   parameter int COORD_BITS  = ntpm_pkg::COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ntpm_pkg::cmd_type             cmd,
   output ntpm_pkg::status_type          status,
   input  ntpm_pkg::req_type             req_payload,
   input  logic [ntpm_pkg::REG_W-1:0]    start_distance,
   input  logic [ntpm_pkg::REG_W-1:0]    pair_threshold,
   input  logic [ntpm_pkg::REG_W-1:0]    single_threshold,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output ntpm_pkg::rsp_type             rsp_payload
);

   localparam int ENTRY_COUNT = CLASS_COUNT * SIZE_COUNT;
   localparam int AW   = $clog2(ENTRY_COUNT);
   localparam int CLW  = $clog2(CLASS_COUNT);
   localparam int CW   = (COORD_BITS < ntpm_pkg::COORD_W) ? COORD_BITS : ntpm_pkg::COORD_W;
   localparam int EW   = 4 * CW + 1;
   localparam int SQ_W = 2 * CW;
   localparam int DW   = ntpm_pkg::DIST_W;

   function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] p, input logic [CW-1:0] q);
      return (p > q) ? (p - q) : (q - p);
   endfunction

   // request decode
   logic size_ok;
   logic class_ok;
   logic [AW-1:0] load_addr;

   assign size_ok   = int'(req_payload.size_index) < SIZE_COUNT;
   assign class_ok  = int'(req_payload.class_index) < CLASS_COUNT;
   assign load_addr = AW'(req_payload.size_index) * AW'(CLASS_COUNT)
                    + AW'(req_payload.class_index);

   assign status.req_is_load = req_payload.kind == ntpm_pkg::KIND_LOAD;
   assign status.req_is_scan = size_ok && (req_payload.kind == ntpm_pkg::KIND_PAIR ||
                                           req_payload.kind == ntpm_pkg::KIND_SINGLE);

   // query context
   ntpm_pkg::kind_type            kind_ff;
   logic [ntpm_pkg::SIZE_W-1:0]   size_ff;
   logic [CW-1:0]                 fx_ff, fy_ff, sx_ff, sy_ff;
   logic [DW-1:0]                 pt_ff, st_ff;

   always_ff @(posedge clock) begin
      if (cmd.start_query) begin
         kind_ff <= req_payload.kind;
         size_ff <= req_payload.size_index;
         fx_ff   <= req_payload.first_x[CW-1:0];
         fy_ff   <= req_payload.first_y[CW-1:0];
         sx_ff   <= req_payload.second_x[CW-1:0];
         sy_ff   <= req_payload.second_y[CW-1:0];
         pt_ff   <= DW'(pair_threshold) * DW'(pair_threshold);
         st_ff   <= DW'(single_threshold) * DW'(single_threshold);
      end
   end

   // entry counter, used by the clearing pass and the scan
   logic [AW-1:0] cnt_ff;
   logic [AW-1:0] cnt_in;

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.start_query) begin
         cnt_in = '0;
      end else if (cmd.clr_step || cmd.scan_step) begin
         cnt_in = cnt_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign status.clr_last  = cnt_ff == AW'(ENTRY_COUNT - 1);
   assign status.scan_last = cnt_ff[CLW-1:0] == CLW'(CLASS_COUNT - 1);

   // template table, valid flag on top of each entry
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [EW-1:0] ram_wr_data;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [EW-1:0] ram_rd_data;

   assign ram_wr_en   = cmd.clr_step || (cmd.load_wr && size_ok && class_ok);
   assign ram_wr_addr = cmd.clr_step ? cnt_ff : load_addr;
   assign ram_wr_data = cmd.clr_step ? EW'(0) :
                        {1'b1, req_payload.first_x[CW-1:0], req_payload.first_y[CW-1:0],
                         req_payload.second_x[CW-1:0], req_payload.second_y[CW-1:0]};
   assign ram_rd_en   = cmd.scan_step;
   assign ram_rd_addr = AW'(size_ff) * AW'(CLASS_COUNT) + AW'(cnt_ff[CLW-1:0]);

   ntpm_ram #(
      .WIDTH (EW),
      .DEPTH (ENTRY_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   logic          tv;
   logic [CW-1:0] ax, ay, bx, by;

   assign tv = ram_rd_data[EW-1];
   assign ax = ram_rd_data[4*CW-1 -: CW];
   assign ay = ram_rd_data[3*CW-1 -: CW];
   assign bx = ram_rd_data[2*CW-1 -: CW];
   assign by = ram_rd_data[CW-1:0];

   // pipeline tags
   logic           rd_vld_ff, a_vld_ff, b_vld_ff, c_vld_ff, d_vld_ff;
   logic           a_tv_ff, b_tv_ff, c_tv_ff, d_tv_ff;
   logic [CLW-1:0] rd_cls_ff, a_cls_ff, b_cls_ff, c_cls_ff, d_cls_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         a_vld_ff  <= 1'b0;
         b_vld_ff  <= 1'b0;
         c_vld_ff  <= 1'b0;
         d_vld_ff  <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.scan_step;
         a_vld_ff  <= rd_vld_ff;
         b_vld_ff  <= a_vld_ff;
         c_vld_ff  <= b_vld_ff;
         d_vld_ff  <= c_vld_ff;
      end
   end

   assign status.pipe_busy = rd_vld_ff || a_vld_ff || b_vld_ff || c_vld_ff || d_vld_ff;

   // distance stages: differences, squares, point distances, pairing
   logic [CW-1:0]   ad_ff [8];
   logic [SQ_W-1:0] sq_ff [8];
   logic [DW-1:0]   d_ff  [4];
   logic [DW-1:0]   err_ff, m1_ff, m2_ff;
   logic [DW-1:0]   e1, e2, err_in, m1_in, m2_in;

   always_comb begin
      e1 = d_ff[0] + d_ff[3];
      e2 = d_ff[1] + d_ff[2];
      if (kind_ff == ntpm_pkg::KIND_SINGLE) begin
         err_in = e1;
         m1_in  = d_ff[0];
         m2_in  = d_ff[1];
      end else if (e1 < e2) begin
         err_in = e1;
         m1_in  = d_ff[0];
         m2_in  = d_ff[3];
      end else begin
         err_in = e2;
         m1_in  = d_ff[2];
         m2_in  = d_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      rd_cls_ff <= cnt_ff[CLW-1:0];
      a_cls_ff  <= rd_cls_ff;
      b_cls_ff  <= a_cls_ff;
      c_cls_ff  <= b_cls_ff;
      d_cls_ff  <= c_cls_ff;
      a_tv_ff   <= tv;
      b_tv_ff   <= a_tv_ff;
      c_tv_ff   <= b_tv_ff;
      d_tv_ff   <= c_tv_ff;
      ad_ff[0]  <= abs_diff(fx_ff, ax);
      ad_ff[1]  <= abs_diff(fy_ff, ay);
      ad_ff[2]  <= abs_diff(fx_ff, bx);
      ad_ff[3]  <= abs_diff(fy_ff, by);
      ad_ff[4]  <= abs_diff(sx_ff, ax);
      ad_ff[5]  <= abs_diff(sy_ff, ay);
      ad_ff[6]  <= abs_diff(sx_ff, bx);
      ad_ff[7]  <= abs_diff(sy_ff, by);
      for (int i = 0; i < 8; i++) begin
         sq_ff[i] <= SQ_W'(ad_ff[i]) * SQ_W'(ad_ff[i]);
      end
      for (int j = 0; j < 4; j++) begin
         d_ff[j] <= DW'(sq_ff[2*j]) + DW'(sq_ff[2*j+1]);
      end
      err_ff <= err_in;
      m1_ff  <= m1_in;
      m2_ff  <= m2_in;
   end

   // best match tracking; best_err holds the lowest squared distance of a one point query
   logic           have_ff, have_in;
   logic [DW-1:0]  best_err_ff, best_err_in;
   logic [DW-1:0]  bd1_ff, bd1_in, bd2_ff, bd2_in;
   logic [CLW-1:0] best_cls_ff, best_cls_in;
   logic           pair_take, single_take;

   assign pair_take   = d_vld_ff && d_tv_ff && (kind_ff == ntpm_pkg::KIND_PAIR) &&
                        (err_ff <= pt_ff) && (!have_ff || err_ff < best_err_ff);
   assign single_take = d_vld_ff && d_tv_ff && (kind_ff == ntpm_pkg::KIND_SINGLE) &&
                        (m1_ff < best_err_ff || m2_ff < best_err_ff);

   always_comb begin
      have_in     = have_ff;
      best_err_in = best_err_ff;
      bd1_in      = bd1_ff;
      bd2_in      = bd2_ff;
      best_cls_in = best_cls_ff;
      if (cmd.start_query) begin
         have_in     = 1'b0;
         best_err_in = DW'(start_distance) * DW'(start_distance);
         best_cls_in = '0;
      end else if (single_take) begin
         have_in     = 1'b1;
         best_err_in = (m1_ff < m2_ff) ? m1_ff : m2_ff;
         best_cls_in = d_cls_ff;
      end else if (pair_take) begin
         have_in     = 1'b1;
         best_err_in = err_ff;
         bd1_in      = m1_ff;
         bd2_in      = m2_ff;
         best_cls_in = d_cls_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else begin
         have_ff <= have_in;
      end
   end

   always_ff @(posedge clock) begin
      best_err_ff <= best_err_in;
      bd1_ff      <= bd1_in;
      bd2_ff      <= bd2_in;
      best_cls_ff <= best_cls_in;
   end

   // result register
   logic              found;
   logic              out_vld_ff, out_vld_in;
   ntpm_pkg::rsp_type out_data_ff;

   assign found = have_ff && ((kind_ff == ntpm_pkg::KIND_SINGLE) ? (best_err_ff <= st_ff) :
                              !(bd1_ff > st_ff && bd2_ff > st_ff));

   always_comb begin
      out_vld_in = out_vld_ff;
      if (cmd.finish) begin
         out_vld_in = 1'b1;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_data_ff.match_class <= found ? ntpm_pkg::CLASS_W'(best_cls_ff) : '0;
         out_data_ff.found       <= found;
      end
   end

   assign status.out_free = !out_vld_ff || rsp_ready;
   assign rsp_valid       = out_vld_ff;
   assign rsp_payload     = out_data_ff;

`ifndef ASSERT_OFF
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!out_vld_ff || rsp_ready))
      else $error("pending result overwritten");

   a_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !status.pipe_busy)
      else $error("result taken before the distance pipeline drained");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      ram_rd_en |-> !ram_wr_en)
      else $error("table written during a scan");

   a_out_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_vld_ff) |-> $past(cmd.finish))
      else $error("result beat without a finished query");
`endif

endmodule

// ===== hdl/nearest_template_point_match.sv =====
// top level of the nearest template point matcher: registers, controller and datapath
//
// Classifies detected points against a table holding one template point pair per class
// and size group (SIZE_COUNT * CLASS_COUNT entries in one ram). After reset a clearing
// pass writes every entry invalid, one per cycle, and req_ready stays low until it is
// done; register writes are taken during that time. A load beat is written into the
// table and gives no result. A two point or one point query reads the entries of its
// size group one per cycle through the distance pipeline, then waits for the pipeline
// to drain and the output register to be free. A query of kind nothing found, or with
// an unsupported size group, gives an unknown result. Each query gives exactly one rsp
// beat; the result sits in an output register so the next load or query can be
// accepted while it waits. The three registers (start distance, pair threshold, single
// threshold) are written through the csr channel, which is always ready, and should
// only change while no query is in flight.
module nearest_template_point_match #(
   parameter int CLASS_COUNT = ntpm_pkg::CLASS_COUNT_DEF,
   parameter int SIZE_COUNT  = ntpm_pkg::SIZE_COUNT_DEF,
   parameter int COORD_BITS  = ntpm_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   // query and load beats
   input  logic                         req_valid,
   output logic                         req_ready,
   input  ntpm_pkg::req_type            req_payload,
   // result beats
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output ntpm_pkg::rsp_type            rsp_payload,
   // register writes
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [ntpm_pkg::CSR_W-1:0]   csr_index,
   input  logic [ntpm_pkg::REG_W-1:0]   csr_data
);

   // configuration registers
   logic [ntpm_pkg::REG_W-1:0] start_distance_ff;
   logic [ntpm_pkg::REG_W-1:0] pair_threshold_ff;
   logic [ntpm_pkg::REG_W-1:0] single_threshold_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_distance_ff   <= ntpm_pkg::START_DISTANCE_RST;
         pair_threshold_ff   <= ntpm_pkg::PAIR_THRESHOLD_RST;
         single_threshold_ff <= ntpm_pkg::SINGLE_THRESHOLD_RST;
      end else if (csr_valid) begin
         // index three has no register and is dropped
         case (csr_index)
            ntpm_pkg::CSR_START_DISTANCE: begin
               start_distance_ff <= csr_data;
            end
            ntpm_pkg::CSR_PAIR_THRESHOLD: begin
               pair_threshold_ff <= csr_data;
            end
            ntpm_pkg::CSR_SINGLE_THRESHOLD: begin
               single_threshold_ff <= csr_data;
            end
            default: begin
               start_distance_ff <= start_distance_ff;
            end
         endcase
      end
   end

   // controller to datapath handshake
   ntpm_pkg::cmd_type    cmd;
   ntpm_pkg::status_type status;

   // sequencer: clearing pass, load writes, scan issue, drain and result hand-off
   ntpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // table, distance pipeline, best match tracking and output register
   ntpm_datapath #(
      .CLASS_COUNT (CLASS_COUNT),
      .SIZE_COUNT  (SIZE_COUNT),
      .COORD_BITS  (COORD_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_payload      (req_payload),
      .start_distance   (start_distance_ff),
      .pair_threshold   (pair_threshold_ff),
      .single_threshold (single_threshold_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload)
   );

endmodule

// ===== sim/tb_top.sv =====
// self-checking testbench for the nearest template point matcher
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLASSES       = ntpm_pkg::CLASS_COUNT_DEF;
   localparam int SIZES         = ntpm_pkg::SIZE_COUNT_DEF;
   localparam int ENTRIES       = CLASSES * SIZES;
   localparam int ITEM_TARGET   = 850;
   localparam int RANDOM_PHASES = 6;
   // a query holds the block through its scan and the pipeline drain, plus margin
   localparam int SETTLE_CYCLES = CLASSES + 40;
   // bound for roughly 900 beats with a busy block, sender gaps and receiver stalls
   localparam int CYCLE_LIMIT   = 700000;
   // csr index with no register behind it
   localparam logic [ntpm_pkg::CSR_W-1:0]   CSR_SPARE = 2'd3;
   localparam logic [ntpm_pkg::REG_W-1:0]   REG_MAX   = '1;
   localparam logic [ntpm_pkg::COORD_W-1:0] COORD_MAX = '1;

   typedef logic [ntpm_pkg::DIST_W-1:0] dist_type;
   typedef struct packed {
      logic [ntpm_pkg::COORD_W-1:0] ax, ay, bx, by;
   } point_pair_type;

   // block ports; the inputs are driven to known values from time zero
   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       req_valid   = 1'b0;
   logic                       req_ready;
   ntpm_pkg::req_type          req_payload = '0;
   logic                       rsp_valid;
   logic                       rsp_ready   = 1'b0;
   ntpm_pkg::rsp_type          rsp_payload;
   logic                       csr_valid   = 1'b0;
   logic                       csr_ready;
   logic [ntpm_pkg::CSR_W-1:0] csr_index   = '0;
   logic [ntpm_pkg::REG_W-1:0] csr_data    = '0;

   // shadow copy of the template table and the registers
   point_pair_type             tpl_points [ENTRIES];
   bit                         tpl_valid [ENTRIES];
   int                         loaded_entries [$];
   logic [ntpm_pkg::REG_W-1:0] start_dist_reg = ntpm_pkg::START_DISTANCE_RST;
   logic [ntpm_pkg::REG_W-1:0] pair_thr_reg   = ntpm_pkg::PAIR_THRESHOLD_RST;
   logic [ntpm_pkg::REG_W-1:0] single_thr_reg = ntpm_pkg::SINGLE_THRESHOLD_RST;

   // predicted match results, oldest first
   ntpm_pkg::rsp_type          expected_matches [$];
   ntpm_pkg::rsp_type          oldest_match;
   int                         mismatch_count = 0;
   int                         cycle_count    = 0;

   // sender pacing state
   int                         burst_left   = 0;
   bit                         steady_phase = 1'b0;

   // receiver stall pattern state
   logic [6:0]                 ready_cycle = '0;
   logic [1:0]                 ready_mode  = '0;

   nearest_template_point_match DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- prediction

   function automatic dist_type sq_distance(logic [ntpm_pkg::COORD_W-1:0] x0, y0, x1, y1);
      dist_type dx, dy;
      dx = (x0 > x1) ? x0 - x1 : x1 - x0;
      dy = (y0 > y1) ? y0 - y1 : y1 - y0;
      return dx * dx + dy * dy;
   endfunction

   // a load overwrites one table entry and marks it valid
   function automatic void store_template(ntpm_pkg::req_type item);
      int entry;
      entry = item.size_index * CLASSES + item.class_index;
      if (item.class_index < CLASSES && item.size_index < SIZES) begin
         if (!tpl_valid[entry]) loaded_entries.push_back(entry);
         tpl_valid[entry]     = 1'b1;
         tpl_points[entry].ax = item.first_x;
         tpl_points[entry].ay = item.first_y;
         tpl_points[entry].bx = item.second_x;
         tpl_points[entry].by = item.second_y;
      end
   endfunction

   // expected result of a query against the current shadow table
   function automatic ntpm_pkg::rsp_type predict_match(ntpm_pkg::req_type item);
      ntpm_pkg::rsp_type res;
      dist_type          pair_lim, single_lim, nearest, best_err, best_d1, best_d2;
      dist_type          d11, d12, d21, d22, err_a, err_b, err, m1, m2;
      point_pair_type    p;
      bit                have;
      int                entry;
      res        = '0;
      have       = 1'b0;
      best_err   = '0;
      best_d1    = '0;
      best_d2    = '0;
      pair_lim   = pair_thr_reg * pair_thr_reg;
      single_lim = single_thr_reg * single_thr_reg;
      nearest    = start_dist_reg * start_dist_reg;
      if (item.kind == ntpm_pkg::KIND_PAIR && item.size_index < SIZES) begin
         for (int c = 0; c < CLASSES; c++) begin
            entry = item.size_index * CLASSES + c;
            if (tpl_valid[entry]) begin
               p     = tpl_points[entry];
               d11   = sq_distance(item.first_x, item.first_y, p.ax, p.ay);
               d12   = sq_distance(item.first_x, item.first_y, p.bx, p.by);
               d21   = sq_distance(item.second_x, item.second_y, p.ax, p.ay);
               d22   = sq_distance(item.second_x, item.second_y, p.bx, p.by);
               err_a = d11 + d22;
               err_b = d12 + d21;
               // straight pairing only when strictly better, crossed otherwise
               if (err_a < err_b) begin
                  err = err_a;
                  m1  = d11;
                  m2  = d22;
               end else begin
                  err = err_b;
                  m1  = d21;
                  m2  = d12;
               end
               // strict compare keeps the earliest class on ties
               if (err <= pair_lim && (!have || err < best_err)) begin
                  have            = 1'b1;
                  best_err        = err;
                  best_d1         = m1;
                  best_d2         = m2;
                  res.match_class = ntpm_pkg::CLASS_W'(c);
               end
            end
         end
         // unknown only when both point distances miss the single threshold
         res.found = have && !(best_d1 > single_lim && best_d2 > single_lim);
      end else if (item.kind == ntpm_pkg::KIND_SINGLE && item.size_index < SIZES) begin
         for (int c = 0; c < CLASSES; c++) begin
            entry = item.size_index * CLASSES + c;
            if (tpl_valid[entry]) begin
               p   = tpl_points[entry];
               d11 = sq_distance(item.first_x, item.first_y, p.ax, p.ay);
               d12 = sq_distance(item.first_x, item.first_y, p.bx, p.by);
               if (d11 < nearest || d12 < nearest) begin
                  nearest         = (d11 < d12) ? d11 : d12;
                  res.match_class = ntpm_pkg::CLASS_W'(c);
                  have            = 1'b1;
               end
            end
         end
         res.found = have && nearest <= single_lim;
      end
      if (!res.found) res.match_class = '0;
      return res;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic ntpm_pkg::req_type make_req(ntpm_pkg::kind_type op, int cls, int size,
                                                  int fx, int fy, int sx, int sy);
      ntpm_pkg::req_type r;
      r.kind        = op;
      r.class_index = ntpm_pkg::CLASS_W'(cls);
      r.size_index  = ntpm_pkg::SIZE_W'(size);
      r.first_x     = ntpm_pkg::COORD_W'(fx);
      r.first_y     = ntpm_pkg::COORD_W'(fy);
      r.second_x    = ntpm_pkg::COORD_W'(sx);
      r.second_y    = ntpm_pkg::COORD_W'(sy);
      return r;
   endfunction

   // coordinate jittered around v, clamped to the coordinate range 0 to COORD_MAX
   function automatic logic [ntpm_pkg::COORD_W-1:0] near_coord(
      logic [ntpm_pkg::COORD_W-1:0] v, int spread);
      int t;
      t = int'(v) + int'($urandom_range(0, 2 * spread)) - spread;
      if (t < 0) t = 0;
      else if (t > int'(COORD_MAX)) t = int'(COORD_MAX);
      return ntpm_pkg::COORD_W'(t);
   endfunction

   // half the template coordinates fall in one cluster so that several templates compete
   function automatic logic [ntpm_pkg::COORD_W-1:0] template_coord();
      if ($urandom_range(0, 1)) return ntpm_pkg::COORD_W'($urandom_range(30000, 34000));
      return ntpm_pkg::COORD_W'($urandom_range(0, COORD_MAX));
   endfunction

   function automatic logic [ntpm_pkg::REG_W-1:0] random_reg();
      case ($urandom_range(0, 3))
         0:       return REG_MAX;
         1:       return ntpm_pkg::REG_W'($urandom_range(0, 8191));
         2:       return ntpm_pkg::REG_W'($urandom_range(0, REG_MAX));
         default: return ntpm_pkg::REG_W'($urandom_range(1024, 6000));
      endcase
   endfunction

   // bursts of random length, then a random gap; steady phases never idle
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 15);
         if (steady_phase) gap = 0;
         else if ($urandom_range(0, 3) == 0) gap = $urandom_range(1, 90);
         else gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // one req beat; the shadow model moves at the accepting edge
   task automatic issue_beat(ntpm_pkg::req_type item);
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (item.kind == ntpm_pkg::KIND_LOAD) store_template(item);
      else expected_matches.push_back(predict_match(item));
      pace_sender();
   endtask

   // drain all results, then give a possibly running load or scan time to finish
   task automatic settle_block();
      req_valid <= 1'b0;
      while (expected_matches.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // writes all three registers, and optionally the unused index, while idle
   task automatic program_registers(logic [ntpm_pkg::REG_W-1:0] start_value, pair_value,
                                    single_value, bit touch_spare);
      logic [ntpm_pkg::CSR_W-1:0] index;
      logic [ntpm_pkg::REG_W-1:0] value;
      settle_block();
      for (int idx = 0; idx < 4; idx++) begin
         index = ntpm_pkg::CSR_W'(idx);
         if (index != CSR_SPARE || touch_spare) begin
            case (index)
               ntpm_pkg::CSR_START_DISTANCE:   value = start_value;
               ntpm_pkg::CSR_PAIR_THRESHOLD:   value = pair_value;
               ntpm_pkg::CSR_SINGLE_THRESHOLD: value = single_value;
               default:                        value = ntpm_pkg::REG_W'($urandom_range(0, REG_MAX));
            endcase
            csr_valid <= 1'b1;
            csr_index <= index;
            csr_data  <= value;
            @(posedge clock);
            while (!csr_ready) @(posedge clock);
            case (index)
               ntpm_pkg::CSR_START_DISTANCE:   start_dist_reg = value;
               ntpm_pkg::CSR_PAIR_THRESHOLD:   pair_thr_reg   = value;
               ntpm_pkg::CSR_SINGLE_THRESHOLD: single_thr_reg = value;
               default:                        ;
            endcase
         end
      end
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------- tests

   // queries on an empty table and nothing-found beats, reset register values
   task automatic test_empty_table();
      issue_beat(make_req(ntpm_pkg::KIND_PAIR, 17, 0, 100, 200, 300, 400));
      issue_beat(make_req(ntpm_pkg::KIND_SINGLE, 0, 3, 32768, 32768, 0, 0));
      issue_beat(make_req(ntpm_pkg::KIND_NONE, 42, 5, 1, 2, 3, 4));
      issue_beat(make_req(ntpm_pkg::KIND_NONE, 63, 7,
                          COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
   endtask

   // hand-built templates: extremes, pairing order, ties, thresholds, reload
   task automatic test_directed_matches();
      // corner template in the last class and size
      issue_beat(make_req(ntpm_pkg::KIND_LOAD, 63, 7, 0, 0, COORD_MAX, COORD_MAX));
      issue_beat(make_req(ntpm_pkg::KIND_PAIR, 3, 7, 0, 0, COORD_MAX, COORD_MAX));
      // swapped query points still match through the crossed pairing
      issue_beat(make_req(ntpm_pkg::KIND_PAIR, 0, 7, COORD_MAX, COORD_MAX, 0, 0));
      // second point of a one point query is ignored
      issue_beat(make_req(ntpm_pkg::KIND_SINGLE, 11, 7, COORD_MAX, COORD_MAX, 1234, 777));
      // nearest point beyond the single threshold
      issue_beat(make_req(ntpm_pkg::KIND_SINGLE, 0, 7, 32768, 32768, 0, 0));
      // two identical templates, the earlier class has to win
      issue_beat(make_req(ntpm_pkg::KIND_LOAD, 5, 1, 10000, 10000, 20000, 20000));
      issue_beat(make_req(ntpm_pkg::KIND_LOAD, 9, 1, 10000, 10000, 20000, 20000));
      issue_beat(make_req(ntpm_pkg::KIND_LOAD, 0, 1, 50000, 50000, 60000, 60000));
      issue_beat(make_req(ntpm_pkg::KIND_PAIR, 40, 1, 10000, 10000, 20000, 20000));
      issue_beat(make_req(ntpm_pkg::KIND_SINGLE, 40, 1, 20000, 20000, 5, 5));
      // within pair threshold but both points miss the single threshold
      issue_beat(make_req(ntpm_pkg::KIND_PAIR, 0, 1, 12500, 10000, 20000, 22500));
      // only one point misses, still a match
      issue_beat(make_req(ntpm_pkg::KIND_PAIR, 0, 1, 12500, 10000, 20000, 20000));
      // no template within the pair threshold
      issue_beat(make_req(ntpm_pkg::KIND_PAIR, 0, 1, 40000, 0, 0, 40000));
      issue_beat(make_req(ntpm_pkg::KIND_SINGLE, 0, 1, 55000, 55000, 0, 0));
      issue_beat(make_req(ntpm_pkg::KIND_SINGLE, 0, 1, 50000, 50000, 0, 0));
      // reload of an entry moves it away, the later twin takes over
      issue_beat(make_req(ntpm_pkg::KIND_LOAD, 5, 1, 30000, 30000, 40000, 40000));
      issue_beat(make_req(ntpm_pkg::KIND_PAIR, 0, 1, 10000, 10000, 20000, 20000));
   endtask

   // register extremes: all zero, all ones, then back to reset values
   task automatic test_threshold_extremes();
      program_registers('0, '0, '0, 1'b1);
      // zero pair threshold accepts an exact pair only
      issue_beat(make_req(ntpm_pkg::KIND_PAIR, 0, 7, 0, 0, COORD_MAX, COORD_MAX));
      issue_beat(make_req(ntpm_pkg::KIND_PAIR, 0, 7, 1, 0, COORD_MAX, COORD_MAX));
      // zero start distance leaves a one point query without candidate
      issue_beat(make_req(ntpm_pkg::KIND_SINGLE, 0, 7, 0, 0, 0, 0));
      program_registers(REG_MAX, REG_MAX, REG_MAX, 1'b0);
      issue_beat(make_req(ntpm_pkg::KIND_PAIR, 0, 7, 32768, 32768, 1, 1));
      issue_beat(make_req(ntpm_pkg::KIND_SINGLE, 0, 1, COORD_MAX, 0, 0, 0));
      issue_beat(make_req(ntpm_pkg::KIND_PAIR, 0, 1, 0, COORD_MAX, COORD_MAX, 0));
      program_registers(ntpm_pkg::START_DISTANCE_RST, ntpm_pkg::PAIR_THRESHOLD_RST,
                        ntpm_pkg::SINGLE_THRESHOLD_RST, 1'b0);
      issue_beat(make_req(ntpm_pkg::KIND_SINGLE, 0, 1, 10000, 10000, 0, 0));
   endtask

   // random phases: loads, queries near stored templates, wild queries, no-base beats
   task automatic test_random_mix();
      ntpm_pkg::req_type item;
      point_pair_type    p;
      int                entry, spread, pick, size_hi, per_phase;
      per_phase = ITEM_TARGET / RANDOM_PHASES;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         program_registers(random_reg(), random_reg(), random_reg(), ph == 0);
         steady_phase = ($urandom_range(0, 3) == 0);
         size_hi      = $urandom_range(0, SIZES - 1);
         for (int n = 0; n < per_phase; n++) begin
            pick             = $urandom_range(0, 99);
            item.class_index = ntpm_pkg::CLASS_W'($urandom_range(0, CLASSES - 1));
            item.size_index  = ntpm_pkg::SIZE_W'($urandom_range(0, SIZES - 1));
            item.first_x     = ntpm_pkg::COORD_W'($urandom);
            item.first_y     = ntpm_pkg::COORD_W'($urandom);
            item.second_x    = ntpm_pkg::COORD_W'($urandom);
            item.second_y    = ntpm_pkg::COORD_W'($urandom);
            if (pick < 25 || loaded_entries.size() == 0) begin
               item.kind       = ntpm_pkg::KIND_LOAD;
               item.size_index = ntpm_pkg::SIZE_W'($urandom_range(0, size_hi));
               item.first_x    = template_coord();
               item.first_y    = template_coord();
               item.second_x   = template_coord();
               item.second_y   = template_coord();
            end else if (pick < 75) begin
               // query built around a stored template
               entry = loaded_entries[$urandom_range(0, loaded_entries.size() - 1)];
               p     = tpl_points[entry];
               case ($urandom_range(0, 3))
                  0:       spread = 0;
                  1:       spread = 200;
                  2:       spread = 1500;
                  default: spread = 5000;
               endcase
               item.size_index = ntpm_pkg::SIZE_W'(entry / CLASSES);
               if (pick < 55) begin
                  item.kind = ntpm_pkg::KIND_PAIR;
                  if ($urandom_range(0, 1)) begin
                     item.first_x  = near_coord(p.ax, spread);
                     item.first_y  = near_coord(p.ay, spread);
                     item.second_x = near_coord(p.bx, spread);
                     item.second_y = near_coord(p.by, spread);
                  end else begin
                     item.first_x  = near_coord(p.bx, spread);
                     item.first_y  = near_coord(p.by, spread);
                     item.second_x = near_coord(p.ax, spread);
                     item.second_y = near_coord(p.ay, spread);
                  end
               end else begin
                  item.kind = ntpm_pkg::KIND_SINGLE;
                  if ($urandom_range(0, 1)) begin
                     item.first_x = near_coord(p.ax, spread);
                     item.first_y = near_coord(p.ay, spread);
                  end else begin
                     item.first_x = near_coord(p.bx, spread);
                     item.first_y = near_coord(p.by, spread);
                  end
               end
            end else if (pick < 92) begin
               item.kind = $urandom_range(0, 1) ? ntpm_pkg::KIND_PAIR : ntpm_pkg::KIND_SINGLE;
            end else begin
               item.kind = ntpm_pkg::KIND_NONE;
            end
            issue_beat(item);
         end
      end
   endtask

   // ---------------------------------------------------------------- response side

   // receiver stall pattern: mode is redrawn each time the 7-bit cycle counter wraps
   always @(posedge clock) begin
      ready_cycle <= ready_cycle + 1'b1;
      if (ready_cycle == '0) ready_mode <= 2'($urandom_range(0, 2));
      case (ready_mode)
         2'd0:    rsp_ready <= 1'b1;
         2'd1:    rsp_ready <= 1'($urandom_range(0, 1));
         // ready while the low five bits of the cycle counter are below 8
         default: rsp_ready <= (ready_cycle[4:0] < 5'd8);
      endcase
   end

   // each accepted result beat against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_matches.size() == 0) begin
            mismatch_count++;
            $display("%0t ns: result beat with nothing expected, actual class %0d found %0b",
                     $time, rsp_payload.match_class, rsp_payload.found);
         end else begin
            oldest_match = expected_matches.pop_front();
            if (rsp_payload.match_class !== oldest_match.match_class) begin
               mismatch_count++;
               $display("%0t ns: match_class expected %0d actual %0d",
                        $time, oldest_match.match_class, rsp_payload.match_class);
            end
            if (rsp_payload.found !== oldest_match.found) begin
               mismatch_count++;
               $display("%0t ns: found expected %0b actual %0b",
                        $time, oldest_match.found, rsp_payload.found);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t ns: timeout after %0d cycles", $time, CYCLE_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      // synchronous reset; the block then clears its table
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_directed_matches();
      test_threshold_extremes();
      test_random_mix();
      settle_block();
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
